@@ src/snwe_pkg.sv @@
package snwe_pkg;

  localparam logic [31:0] HashMul  = 32'd101;
  localparam logic [23:0] HashMask = 24'hffffff;
  localparam logic [31:0] HashLow  = 32'h00000fff;
  localparam logic [6:0]  AsciiTag = 7'd127;

  localparam logic [4:0] CodeUnder = 5'd1;
  localparam logic [4:0] CodeDash  = 5'd28;
  localparam logic [4:0] CodeQuest = 5'd29;
  localparam logic [4:0] CodeSlash = 5'd30;

  localparam int NameLen = 6;

  localparam logic [1:0] KindNil    = 2'd0;
  localparam logic [1:0] KindAscii  = 2'd1;
  localparam logic [1:0] KindPacked = 2'd2;
  localparam logic [1:0] KindHashed = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       no_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] symbol_word;
    logic [1:0]  kind;
    logic        needs_binding;
  } result_t;

  function automatic logic [4:0] pack_code(input logic [7:0] c);
    logic [7:0] diff;
    logic [4:0] code;
    diff = c - 8'd95;
    code = 5'd0;
    if (c == 8'h5f) begin
      code = CodeUnder;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      code = diff[4:0];
    end else if (c == 8'h2d) begin
      code = CodeDash;
    end else if (c == 8'h3f) begin
      code = CodeQuest;
    end else if (c == 8'h2f) begin
      code = CodeSlash;
    end
    return code;
  endfunction

endpackage

@@ src/snwe_in_stage.sv @@
module snwe_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               no_char,
  input  logic               last,
  input  logic               take,
  output snwe_pkg::item_t    item
);

  logic       valid;
  logic [7:0] ch_q;
  logic       no_char_q;
  logic       last_q;

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q      <= ch;
      no_char_q <= no_char;
      last_q    <= last;
    end
  end

  always_comb begin
    item.valid   = valid;
    item.ch      = ch_q;
    item.no_char = no_char_q;
    item.last    = last_q;
  end

endmodule

@@ src/snwe_core.sv @@
module snwe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         hash_seed,
  input  snwe_pkg::item_t     item,
  input  logic                out_free,
  output logic                take,
  output logic                res_load,
  output snwe_pkg::result_t   res
);

  logic [2:0]  count;
  logic [7:0]  chars [snwe_pkg::NameLen];
  logic [31:0] acc;
  logic        pack_ok;
  logic        ascii_ok;
  logic        ended;

  logic [2:0]  count_next;
  logic [7:0]  chars_next [snwe_pkg::NameLen];
  logic [31:0] acc_next;
  logic        pack_ok_next;
  logic        ascii_ok_next;
  logic        ended_next;

  logic [31:0] base;
  logic [31:0] folded;
  logic [29:0] packed_codes;
  logic        is_nil;

  assign take     = item.valid && (!item.last || out_free);
  assign res_load = take && item.last;

  // per-character update
  always_comb begin
    count_next    = count;
    chars_next    = chars;
    acc_next      = acc;
    pack_ok_next  = pack_ok;
    ascii_ok_next = ascii_ok;
    ended_next    = ended;
    base          = (count == 3'd0) ? hash_seed : acc;
    if (!item.no_char && !ended) begin
      if (item.ch == 8'd0) begin
        ended_next = 1'b1;
      end else begin
        acc_next = base * snwe_pkg::HashMul + {24'd0, item.ch};
        if (item.ch[7]) begin
          ascii_ok_next = 1'b0;
        end
        if (snwe_pkg::pack_code(item.ch) == 5'd0) begin
          pack_ok_next = 1'b0;
        end
        if (count < 3'd6) begin
          chars_next[count] = item.ch;
        end
        if (count != 3'd7) begin
          count_next = count + 3'd1;
        end
      end
    end
  end

  // encode from the updated name
  always_comb begin
    folded = acc_next ^ (acc_next >> 16) ^ (acc_next << 16);
    packed_codes = {snwe_pkg::pack_code(chars_next[0]), snwe_pkg::pack_code(chars_next[1]),
                    snwe_pkg::pack_code(chars_next[2]), snwe_pkg::pack_code(chars_next[3]),
                    snwe_pkg::pack_code(chars_next[4]), snwe_pkg::pack_code(chars_next[5])};
    is_nil = (count_next == 3'd3) && (chars_next[0] == 8'h6e) &&
             (chars_next[1] == 8'h69) && (chars_next[2] == 8'h6c);
    res.needs_binding = 1'b0;
    if (is_nil) begin
      res.symbol_word = 32'd0;
      res.kind        = snwe_pkg::KindNil;
    end else if (count_next <= 3'd3 && ascii_ok_next) begin
      res.symbol_word = {chars_next[0][6:0], chars_next[1][6:0], chars_next[2][6:0],
                         4'd0, snwe_pkg::AsciiTag};
      res.kind        = snwe_pkg::KindAscii;
    end else if (count_next >= 3'd4 && count_next <= 3'd6 && pack_ok_next) begin
      res.symbol_word = {packed_codes, 2'b11};
      res.kind        = snwe_pkg::KindPacked;
    end else begin
      res.symbol_word = {folded[23:0] & snwe_pkg::HashMask, 8'd0} | snwe_pkg::HashLow;
      res.kind        = snwe_pkg::KindHashed;
      res.needs_binding = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 3'd0;
      acc      <= 32'd0;
      pack_ok  <= 1'b1;
      ascii_ok <= 1'b1;
      ended    <= 1'b0;
      for (int i = 0; i < snwe_pkg::NameLen; i++) begin
        chars[i] <= 8'd0;
      end
    end else if (take) begin
      if (item.last) begin
        count    <= 3'd0;
        acc      <= hash_seed;
        pack_ok  <= 1'b1;
        ascii_ok <= 1'b1;
        ended    <= 1'b0;
        for (int i = 0; i < snwe_pkg::NameLen; i++) begin
          chars[i] <= 8'd0;
        end
      end else begin
        count    <= count_next;
        acc      <= acc_next;
        pack_ok  <= pack_ok_next;
        ascii_ok <= ascii_ok_next;
        ended    <= ended_next;
        chars    <= chars_next;
      end
    end
  end

  // name state is cleared after every result
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_load |=> count == 3'd0 && pack_ok && ascii_ok && !ended)
    else $error("name state not cleared after result");

  // a non-ascii byte never has a packing code
  a_ascii_implies_pack: assert property (@(posedge clk) disable iff (rst)
    !ascii_ok |-> !pack_ok)
    else $error("ascii flag dropped without pack flag");

  // any failed flag means a character was counted
  a_flag_needs_char: assert property (@(posedge clk) disable iff (rst)
    !pack_ok |-> count != 3'd0)
    else $error("pack flag dropped on empty name");

endmodule

@@ src/snwe_out_reg.sv @@
module snwe_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_load,
  input  snwe_pkg::result_t   res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         symbol_word,
  output logic [1:0]          kind,
  output logic                needs_binding
);

  snwe_pkg::result_t held;

  assign out_free      = !out_valid || out_ready;
  assign symbol_word   = held.symbol_word;
  assign kind          = held.kind;
  assign needs_binding = held.needs_binding;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid || out_ready)
    else $error("result overwritten before transfer");

  // binding flag only on hashed names
  a_binding_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> needs_binding == (kind == snwe_pkg::KindHashed))
    else $error("binding flag does not match kind");

endmodule

@@ src/symbol_name_word_encoder_unit.sv @@
// symbol name word encoder
// input channel: one character of a name per transfer (ch, no_char, last) on
//   in_valid / in_ready. no_char marks a transfer that only carries last.
//   a zero character ends the name and later characters are dropped.
// output channel: one transfer per name on out_valid / out_ready, issued for
//   the input transfer with last set: symbol_word, kind, needs_binding.
// order: a transfer with last is first registered in the input stage, then
//   its result is loaded into the output register, where out_valid rises.
// throughput: one character per cycle unless a last transfer stalls; set by
//   the single update stage (multiply-add by 101 on the hash, encode muxes).
// stall: the finished result waits in the output register; characters
//   without last keep flowing, a transfer with last waits until the output
//   register is free, and in_ready drops only then.
// config: apb register 0 at address 0 is hash_seed, used on the first
//   character of each name. pready is always high.
// reset: synchronous, clears both channels, the name state and hash_seed.
module symbol_name_word_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        no_char,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] symbol_word,
  output logic [1:0]  kind,
  output logic        needs_binding,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              [31:0] hash_seed;
  snwe_pkg::item_t          item;
  snwe_pkg::result_t        res;
  logic                     take;
  logic                     res_load;
  logic                     out_free;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? hash_seed : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 32'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      hash_seed <= pwdata;
    end
  end

  snwe_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .no_char  (no_char),
    .last     (last),
    .take     (take),
    .item     (item)
  );

  snwe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .hash_seed (hash_seed),
    .item      (item),
    .out_free  (out_free),
    .take      (take),
    .res_load  (res_load),
    .res       (res)
  );

  snwe_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_load      (res_load),
    .res           (res),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol_word   (symbol_word),
    .kind          (kind),
    .needs_binding (needs_binding)
  );

endmodule
